// ----- hdl/alb_pkg.sv -----
package alb_pkg;

    // result kinds
    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_HEADER   = 3'd1;
    localparam logic [2:0] KIND_BLOCK_OK = 3'd2;
    localparam logic [2:0] KIND_BAD_SUM  = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;
    localparam logic [2:0] KIND_BAD_LEN  = 3'd5;

    localparam int WORD_W       = 36;
    localparam int HDR_BYTES    = 6;

    // byte queue between front and back
    localparam int BQ_DEPTH = 4;
    localparam int BQ_AW    = $clog2(BQ_DEPTH);

    // result queue at the output
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    typedef struct packed {
        logic [7:0] value;
        logic       wend;   // final byte of its word
    } t_byte;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] block_type;
        logic [15:0] load_address;
        logic [15:0] byte_count;
        logic [7:0]  byte_value;
        logic        last;
    } t_result;

endpackage

// ----- hdl/alb_front.sv -----
module alb_front import alb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [WORD_W-1:0] i_packed_word,
    output logic              o_bq_push,
    input  logic              i_bq_full,
    output t_byte             o_bq_data
);

    logic [WORD_W-1:0] r_word;
    logic              r_valid;
    logic [1:0]        r_idx;
    logic              fire;
    logic              accept;

    assign fire      = r_valid && !i_bq_full;
    assign full      = r_valid && !(fire && (r_idx == 2'd3));
    assign accept    = push && !full;
    assign o_bq_push = fire;

    // byte order: bits 18-25, 26-33, 0-7, 8-15
    always_comb begin
        case (r_idx)
            2'd0:    o_bq_data.value = r_word[25:18];
            2'd1:    o_bq_data.value = r_word[33:26];
            2'd2:    o_bq_data.value = r_word[7:0];
            default: o_bq_data.value = r_word[15:8];
        endcase
        o_bq_data.wend = (r_idx == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (accept) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (fire) begin
            if (r_idx == 2'd3) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_packed_word;
        end
    end

endmodule

// ----- hdl/alb_byte_queue.sv -----
module alb_byte_queue import alb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_byte i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_byte o_data
);

    t_byte            r_mem [BQ_DEPTH];
    logic [BQ_AW-1:0] r_wp;
    logic [BQ_AW-1:0] r_rp;
    logic [BQ_AW:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (BQ_AW+1)'(BQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- hdl/alb_back.sv -----
module alb_back import alb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_bq_empty,
    input  t_byte   i_bq_data,
    output logic    o_bq_pop,
    input  logic    i_rq_full,
    output logic    o_rq_push,
    output t_result o_rq_data
);

    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_TYPE_HI = 4'd1;
    localparam logic [3:0] PH_LEN_LO  = 4'd2;
    localparam logic [3:0] PH_LEN_HI  = 4'd3;
    localparam logic [3:0] PH_ADR_LO  = 4'd4;
    localparam logic [3:0] PH_ADR_HI  = 4'd5;
    localparam logic [3:0] PH_DATA    = 4'd6;
    localparam logic [3:0] PH_CHECK   = 4'd7;
    localparam logic [3:0] PH_DONE    = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_type, n_type;
    logic [15:0] r_remaining, n_remaining;
    logic [15:0] r_next_addr, n_next_addr;
    logic [7:0]  r_cnt_lo, n_cnt_lo;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_block_len, n_block_len;

    logic        r_hold_v;
    t_result     r_hold;
    logic        r_flush;

    logic        take;
    logic        res_v;
    t_result     res;
    logic [7:0]  b;
    logic [7:0]  sum_b;
    logic [15:0] word;
    logic [15:0] rem_hdr;
    logic [15:0] rem_dec;

    assign take     = !r_flush && !i_bq_empty && !i_rq_full;
    assign o_bq_pop = take;
    assign b        = i_bq_data.value;
    assign sum_b    = r_sum + b;
    assign word     = {b, r_cnt_lo};
    assign rem_hdr  = r_remaining - 16'(HDR_BYTES);
    assign rem_dec  = r_remaining - 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_remaining = r_remaining;
        n_next_addr = r_next_addr;
        n_cnt_lo    = r_cnt_lo;
        n_sum       = r_sum;
        n_block_len = r_block_len;
        res_v       = 1'b0;
        res.kind         = KIND_DATA;
        res.block_type   = r_type;
        res.load_address = r_next_addr;
        res.byte_count   = r_block_len;
        res.byte_value   = b;
        res.last         = 1'b0;
        unique case (r_phase)
            PH_DONE: begin
            end
            PH_TYPE_HI: begin
                n_sum   = sum_b;
                n_type  = {b, r_type[7:0]};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_sum    = sum_b;
                n_cnt_lo = b;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_sum       = sum_b;
                n_remaining = {b, r_cnt_lo};
                n_phase     = PH_ADR_LO;
            end
            PH_ADR_LO: begin
                n_sum    = sum_b;
                n_cnt_lo = b;
                n_phase  = PH_ADR_HI;
            end
            PH_ADR_HI: begin
                n_sum            = sum_b;
                n_next_addr      = word;
                res_v            = 1'b1;
                res.load_address = word;
                res.byte_value   = 8'd0;
                if (r_remaining < 16'(HDR_BYTES)) begin
                    // short count: flag and go back to hunting
                    res.kind       = KIND_BAD_LEN;
                    res.byte_count = r_remaining;
                    n_phase        = PH_HUNT;
                end else begin
                    n_remaining = rem_hdr;
                    n_block_len = rem_hdr;
                    res.byte_count = rem_hdr;
                    if (rem_hdr == 16'd0) begin
                        res.kind = KIND_END;
                        n_phase  = PH_DONE;
                    end else begin
                        res.kind = KIND_HEADER;
                        n_phase  = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_sum       = sum_b;
                res_v       = 1'b1;
                res.kind    = KIND_DATA;
                n_next_addr = r_next_addr + 16'd1;
                n_remaining = rem_dec;
                if (rem_dec == 16'd0) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_sum    = sum_b;
                res_v    = 1'b1;
                res.kind = (sum_b == 8'd0) ? KIND_BLOCK_OK : KIND_BAD_SUM;
                n_phase  = PH_HUNT;
            end
            default: begin
                // hunting: skip zero bytes, a nonzero byte opens a block
                if (b != 8'd0) begin
                    n_sum   = b;
                    n_type  = {8'd0, b};
                    n_phase = PH_TYPE_HI;
                end
            end
        endcase
    end

    // One result of each word is held back until the next one (or the word's
    // end) shows whether it is the word's final result.
    always_comb begin
        o_rq_push = 1'b0;
        o_rq_data = r_hold;
        if (r_flush) begin
            o_rq_push      = !i_rq_full;
            o_rq_data.last = 1'b1;
        end else if (take) begin
            if (res_v && r_hold_v) begin
                o_rq_push      = 1'b1;
                o_rq_data.last = 1'b0;
            end else if (res_v && i_bq_data.wend) begin
                o_rq_push      = 1'b1;
                o_rq_data      = res;
                o_rq_data.last = 1'b1;
            end else if (r_hold_v && i_bq_data.wend) begin
                o_rq_push      = 1'b1;
                o_rq_data.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_type      <= '0;
            r_remaining <= '0;
            r_next_addr <= '0;
            r_cnt_lo    <= '0;
            r_sum       <= '0;
            r_block_len <= '0;
            r_hold_v    <= 1'b0;
            r_flush     <= 1'b0;
        end else if (r_flush) begin
            if (!i_rq_full) begin
                r_flush  <= 1'b0;
                r_hold_v <= 1'b0;
            end
        end else if (take) begin
            r_phase     <= n_phase;
            r_type      <= n_type;
            r_remaining <= n_remaining;
            r_next_addr <= n_next_addr;
            r_cnt_lo    <= n_cnt_lo;
            r_sum       <= n_sum;
            r_block_len <= n_block_len;
            if (res_v && r_hold_v) begin
                r_flush <= i_bq_data.wend;
            end else if (res_v && !i_bq_data.wend) begin
                r_hold_v <= 1'b1;
            end else if (i_bq_data.wend) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_v && !r_flush) begin
            r_hold <= res;
        end
    end

endmodule

// ----- hdl/alb_result_queue.sv -----
module alb_result_queue import alb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_data
);

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp;
    logic [RQ_AW-1:0] r_rp;
    logic [RQ_AW:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (RQ_AW+1)'(RQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- hdl/absolute_loader_block_parser.sv -----
// A taken word is registered in the front, which can take the next word as
//   the last byte of this one goes to the byte queue and on to the parser.
// The parser takes one byte a cycle unless the byte queue is empty, the result
//   queue is full, or it is flushing a held result as a word's final result.
// Reset (synchronous, active low): queues empty, parser back to hunting with
//   all block state cleared; an end of load is forgotten.
module absolute_loader_block_parser import alb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [WORD_W-1:0] i_packed_word,
    output logic              empty,
    input  logic              pop,
    output logic [2:0]        o_kind,
    output logic [15:0]       o_block_type,
    output logic [15:0]       o_load_address,
    output logic [15:0]       o_byte_count,
    output logic [7:0]        o_byte_value,
    output logic              o_last
);

    // front to back byte stream
    logic    bq_push;
    logic    bq_full;
    t_byte   bq_wdata;
    logic    bq_pop;
    logic    bq_empty;
    t_byte   bq_rdata;

    // back to output queue
    logic    rq_push;
    logic    rq_full;
    t_result rq_wdata;
    t_result rq_rdata;

    // Front: hold one word and split it into bytes in tape order.
    alb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_packed_word (i_packed_word),
        .o_bq_push     (bq_push),
        .i_bq_full     (bq_full),
        .o_bq_data     (bq_wdata)
    );

    // Short byte queue decouples the splitter from the parser.
    alb_byte_queue u_bq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bq_push),
        .i_data  (bq_wdata),
        .o_full  (bq_full),
        .i_pop   (bq_pop),
        .o_empty (bq_empty),
        .o_data  (bq_rdata)
    );

    // Back: block parser, one byte a cycle unless stalled, tags final per word.
    alb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bq_empty (bq_empty),
        .i_bq_data  (bq_rdata),
        .o_bq_pop   (bq_pop),
        .i_rq_full  (rq_full),
        .o_rq_push  (rq_push),
        .o_rq_data  (rq_wdata)
    );

    // Result queue: hold finished requests until the consumer pops them.
    alb_result_queue u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_wdata),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (rq_rdata)
    );

    assign o_kind         = rq_rdata.kind;
    assign o_block_type   = rq_rdata.block_type;
    assign o_load_address = rq_rdata.load_address;
    assign o_byte_count   = rq_rdata.byte_count;
    assign o_byte_value   = rq_rdata.byte_value;
    assign o_last         = rq_rdata.last;

endmodule

// ----- test/tb_absolute_loader_block_parser.sv -----
`timescale 1ns / 100ps

module tb_absolute_loader_block_parser;
    import alb_pkg::*;

    // Idle cycles without any request moving before the run is declared hung.
    localparam int IDLE_LIMIT   = 1000;
    // Random words after the directed table, before the closing rows.
    localparam int RANDOM_WORDS = 150;
    // Settle time after the last result.
    localparam int SETTLE_CYCLES = 24;

    // Parser position inside the tape byte stream.
    typedef enum logic [3:0] {
        SEEK_TYPE,
        GET_TYPE_HI,
        GET_CNT_LO,
        GET_CNT_HI,
        GET_ADR_LO,
        GET_ADR_HI,
        IN_DATA,
        GET_SUM,
        LOAD_DONE
    } t_tape_phase;

    typedef struct packed {
        t_tape_phase phase;
        logic [15:0] btype;   // block type word
        logic [15:0] left;    // count, then data bytes still to come
        logic [15:0] addr;    // address of the next data byte
        logic [15:0] len;     // data length of the current block
        logic [7:0]  held;    // low byte of a 16-bit header field
        logic [7:0]  sum;     // running block checksum
    } t_tape;

    // One row of the directed table. Where typed is set, rec (or nothing, when
    // has_rec is clear) replaces what the parser model predicts for the word.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              typed;
        logic              has_rec;
        t_result           rec;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [WORD_W-1:0] i_packed_word = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [2:0]        o_kind;
    logic [15:0]       o_block_type;
    logic [15:0]       o_load_address;
    logic [15:0]       o_byte_count;
    logic [7:0]        o_byte_value;
    logic              o_last;

    t_result due_q[$];        // results still owed by the block, oldest first
    t_row    stim_rows[$];
    t_tape   tape_st;         // parser model, advanced on accepted words
    t_tape   plan_st;         // look-ahead copy used to shape random words
    int      fail_cnt = 0;
    int      idle_cycles = 0;
    int      gap_cycles = 0;
    int      burst_left = 8;
    logic [7:0] cnt_hi_plan = '0;
    logic    big_due = 1'b0;
    logic    closing = 1'b0;

    absolute_loader_block_parser DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_packed_word  (i_packed_word),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_block_type   (o_block_type),
        .o_load_address (o_load_address),
        .o_byte_count   (o_byte_count),
        .o_byte_value   (o_byte_value),
        .o_last         (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance the parser model by one tape byte; hit flags a result in r.
    function automatic t_tape tape_step(input t_tape s, input logic [7:0] b,
                                        output t_result r, output logic hit);
        t_tape       n;
        logic [15:0] w16;
        n   = s;
        r   = '0;
        hit = 1'b0;
        case (s.phase)
            LOAD_DONE: ;
            GET_TYPE_HI: begin
                n.sum   = s.sum + b;
                n.btype = s.btype | {b, 8'h00};
                n.phase = GET_CNT_LO;
            end
            GET_CNT_LO: begin
                n.sum   = s.sum + b;
                n.held  = b;
                n.phase = GET_CNT_HI;
            end
            GET_CNT_HI: begin
                n.sum   = s.sum + b;
                n.left  = {b, s.held};
                n.phase = GET_ADR_LO;
            end
            GET_ADR_LO: begin
                n.sum   = s.sum + b;
                n.held  = b;
                n.phase = GET_ADR_HI;
            end
            GET_ADR_HI: begin
                n.sum  = s.sum + b;
                w16    = {b, s.held};
                n.addr = w16;
                hit    = 1'b1;
                if (s.left < HDR_BYTES) begin
                    // short count: report it and hunt for the next block
                    r       = {KIND_BAD_LEN, s.btype, w16, s.left, 8'h00, 1'b0};
                    n.phase = SEEK_TYPE;
                end else begin
                    n.left = s.left - 16'(HDR_BYTES);
                    n.len  = n.left;
                    if (n.left == 16'h0000) begin
                        r       = {KIND_END, s.btype, w16, 16'h0000, 8'h00, 1'b0};
                        n.phase = LOAD_DONE;
                    end else begin
                        r       = {KIND_HEADER, s.btype, w16, n.left, 8'h00, 1'b0};
                        n.phase = IN_DATA;
                    end
                end
            end
            IN_DATA: begin
                n.sum  = s.sum + b;
                r      = {KIND_DATA, s.btype, s.addr, s.len, b, 1'b0};
                hit    = 1'b1;
                n.addr = s.addr + 16'd1;
                n.left = s.left - 16'd1;
                if (n.left == 16'h0000) begin
                    n.phase = GET_SUM;
                end
            end
            GET_SUM: begin
                n.sum   = s.sum + b;
                r       = {(n.sum == 8'h00) ? KIND_BLOCK_OK : KIND_BAD_SUM,
                           s.btype, s.addr, s.len, b, 1'b0};
                hit     = 1'b1;
                n.phase = SEEK_TYPE;
            end
            default: begin
                // hunting: zero bytes are skipped, the first other byte opens a block
                if (b != 8'h00) begin
                    n.sum   = b;
                    n.btype = {8'h00, b};
                    n.phase = GET_TYPE_HI;
                end
            end
        endcase
        return n;
    endfunction

    // Results of one accepted word, in byte order 18-25, 26-33, 0-7, 8-15.
    function automatic int word_records(input logic [WORD_W-1:0] w,
                                        output t_result [3:0] recs);
        logic [3:0][7:0] bytes;
        t_result         r;
        logic            hit;
        int              n;
        int              k;
        bytes = {w[15:8], w[7:0], w[33:26], w[25:18]};
        recs  = '0;
        n     = 0;
        for (k = 0; k < 4; k++) begin
            tape_st = tape_step(tape_st, bytes[k], r, hit);
            if (hit) begin
                recs[n] = r;
                n++;
            end
        end
        if (n > 0) begin
            recs[n-1].last = 1'b1;
        end
        return n;
    endfunction

    // Build a word from its four tape bytes plus the four unused bits.
    function automatic logic [WORD_W-1:0] pack_bytes(input logic [7:0] b0, input logic [7:0] b1,
                                                     input logic [7:0] b2, input logic [7:0] b3,
                                                     input logic [3:0] spare);
        return {spare[3:2], b1, b0, spare[1:0], b3, b2};
    endfunction

    // A lone result of a word, so it is also the word's last.
    function automatic t_result one_rec(input logic [2:0] kind, input logic [15:0] btype,
                                        input logic [15:0] addr, input logic [15:0] cnt,
                                        input logic [7:0] val);
        return {kind, btype, addr, cnt, val, 1'b1};
    endfunction

    // Choose the next tape byte from where the look-ahead parser stands, so that
    // most of the stream is well formed blocks with random content.
    function automatic logic [7:0] plan_byte();
        logic [15:0] cnt;
        logic [7:0]  b;
        t_result     r;
        logic        hit;
        int          roll;
        roll = $urandom_range(0, 99);
        case (plan_st.phase)
            SEEK_TYPE: begin
                // drop zero filler now and then; only filler once closing
                b = (closing || roll < 25) ? 8'h00 : 8'($urandom_range(1, 255));
            end
            GET_TYPE_HI: begin
                b = 8'($urandom_range(0, 255));
            end
            GET_CNT_LO: begin
                // never exactly six: that would end the load too early
                if (roll < 10) begin
                    cnt = 16'($urandom_range(0, 5));
                end else if (big_due) begin
                    cnt     = 16'h0100 + 16'($urandom_range(0, 7));
                    big_due = 1'b0;
                end else if (roll < 25) begin
                    cnt = 16'(HDR_BYTES + $urandom_range(13, 40));
                end else begin
                    cnt = 16'(HDR_BYTES + $urandom_range(1, 12));
                end
                cnt_hi_plan = cnt[15:8];
                b = cnt[7:0];
            end
            GET_CNT_HI: begin
                b = cnt_hi_plan;
            end
            GET_ADR_LO, GET_ADR_HI: begin
                // all ones pushes the base close to the address wrap
                b = (roll < 12) ? 8'hFF : 8'($urandom_range(0, 255));
            end
            GET_SUM: begin
                b = (roll < 80) ? 8'(-plan_st.sum) : 8'($urandom_range(0, 255));
            end
            default: begin
                b = (roll < 6) ? 8'h00 : (roll < 12) ? 8'hFF : 8'($urandom_range(0, 255));
            end
        endcase
        plan_st = tape_step(plan_st, b, r, hit);
        return b;
    endfunction

    task automatic add_row(input logic [WORD_W-1:0] word, input logic typed,
                           input logic has_rec, input t_result rec);
        t_row row;
        row.word    = word;
        row.typed   = typed;
        row.has_rec = has_rec;
        row.rec     = rec;
        stim_rows.push_back(row);
    endtask

    // Offer one word, hold it until taken, then book what it is owed.
    task automatic send_word(input logic [WORD_W-1:0] w, input logic typed,
                             input logic has_rec, input t_result rec);
        t_result [3:0] recs;
        int            n;
        int            k;
        if (gap_cycles > 0) begin
            push <= 1'b0;
            repeat (gap_cycles) @(posedge i_clk);
            gap_cycles = 0;
        end
        push          <= 1'b1;
        i_packed_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n = word_records(w, recs);
        if (typed) begin
            if (has_rec) begin
                due_q.push_back(rec);
            end
        end else begin
            for (k = 0; k < n; k++) begin
                due_q.push_back(recs[k]);
            end
        end
        // end of a burst: schedule a gap, sometimes none to run back to back
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
    endtask

    // Hold the sender until every owed result has come out.
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (due_q.size() != 0);
    endtask

    task automatic note_fail(input string what, input t_result want, input t_result got);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected kind %0d type %h addr %h count %h value %h last %b",
                     want.kind, want.block_type, want.load_address, want.byte_count,
                     want.byte_value, want.last);
            $display("  actual   kind %0d type %h addr %h count %h value %h last %b",
                     got.kind, got.block_type, got.load_address, got.byte_count,
                     got.byte_value, got.last);
        end
    endtask

    // Receiver: pick a stall pattern whenever pop_cyc[5:0] is zero - always ready,
    // coin flip, one pop in four, or mostly ready.
    logic [1:0] pop_mode = 2'd0;
    logic [7:0] pop_cyc = '0;

    always @(posedge i_clk) begin
        pop_cyc <= pop_cyc + 8'd1;
        if (pop_cyc[5:0] == 6'd0) begin
            pop_mode <= 2'($urandom_range(0, 3));
        end
        case (pop_mode)
            2'd0: pop <= 1'b1;
            2'd1: pop <= 1'($urandom_range(0, 1));
            2'd2: pop <= (pop_cyc[1:0] == 2'd3);
            default: pop <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Compare each popped result with the oldest owed one.
    t_result got_rec;

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            got_rec = {o_kind, o_block_type, o_load_address, o_byte_count,
                       o_byte_value, o_last};
            if (due_q.size() == 0) begin
                note_fail("result with nothing owed", '0, got_rec);
            end else if (got_rec !== due_q[0]) begin
                note_fail("result mismatch", due_q[0], got_rec);
                void'(due_q.pop_front());
            end else begin
                void'(due_q.pop_front());
            end
        end
    end

    // Hang detection: any request moving on either side resets the count.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row            row;
        logic [7:0]      b0;
        logic [7:0]      b1;
        logic [7:0]      b2;
        logic [7:0]      b3;
        int              n_open;
        int              n_rand;
        int              i;

        tape_st       = '0;
        tape_st.phase = SEEK_TYPE;

        // Opening rows, from reset. Typed rows are read straight off the format.
        add_row(36'h0_0000_0000, 1'b1, 1'b0, '0);             // nothing after reset
        add_row(36'hC_0003_0000, 1'b1, 1'b0, '0);             // unused bits only
        // type FF01, 3 bytes at FFFE: data wraps through 0000, good checksum
        add_row(pack_bytes(8'h01, 8'hFF, 8'h09, 8'h00, 4'h0), 1'b0, 1'b0, '0);
        add_row(pack_bytes(8'hFE, 8'hFF, 8'h00, 8'hFF, 4'hF), 1'b0, 1'b0, '0);
        add_row(pack_bytes(8'h80, 8'h7B, 8'h00, 8'h00, 4'h5), 1'b0, 1'b0, '0);
        // type FFFF, one byte at 1234, wrong checksum
        add_row(pack_bytes(8'hFF, 8'hFF, 8'h07, 8'h00, 4'hA), 1'b0, 1'b0, '0);
        add_row(pack_bytes(8'h34, 8'h12, 8'hAA, 8'h00, 4'h0), 1'b0, 1'b0, '0);
        // short counts: five, then zero
        add_row(pack_bytes(8'h05, 8'h00, 8'h05, 8'h00, 4'h3), 1'b0, 1'b0, '0);
        add_row(pack_bytes(8'h00, 8'h80, 8'h00, 8'h00, 4'hC), 1'b1, 1'b1,
                one_rec(KIND_BAD_LEN, 16'h0005, 16'h8000, 16'd5, 8'h00));
        add_row(pack_bytes(8'h7F, 8'h00, 8'h00, 8'h00, 4'h0), 1'b0, 1'b0, '0);
        add_row(pack_bytes(8'hFF, 8'hFF, 8'h00, 8'h00, 4'hF), 1'b1, 1'b1,
                one_rec(KIND_BAD_LEN, 16'h007F, 16'hFFFF, 16'd0, 8'h00));
        // type 0080, four bytes at 0000, three results in each of two words
        add_row(pack_bytes(8'h80, 8'h00, 8'h0A, 8'h00, 4'h6), 1'b0, 1'b0, '0);
        add_row(pack_bytes(8'h00, 8'h00, 8'h11, 8'h22, 4'h9), 1'b0, 1'b0, '0);
        add_row(pack_bytes(8'h33, 8'h44, 8'hCC, 8'h00, 4'h0), 1'b0, 1'b0, '0);
        // header lands on the first byte of a word: four results from one word
        add_row(pack_bytes(8'h00, 8'h00, 8'h00, 8'h01, 4'h0), 1'b0, 1'b0, '0);
        add_row(pack_bytes(8'h00, 8'h0B, 8'h00, 8'h20, 4'hF), 1'b0, 1'b0, '0);
        add_row(pack_bytes(8'h40, 8'hA1, 8'hA2, 8'hA3, 4'h2), 1'b0, 1'b0, '0);
        add_row(pack_bytes(8'hA4, 8'hA5, 8'h65, 8'h00, 4'hD), 1'b0, 1'b0, '0);
        n_open = stim_rows.size();
        // Closing rows: count of exactly six ends the load, then all is ignored.
        add_row(pack_bytes(8'h06, 8'h00, 8'h06, 8'h00, 4'h0), 1'b1, 1'b0, '0);
        add_row(pack_bytes(8'h34, 8'h12, 8'h00, 8'h00, 4'hF), 1'b1, 1'b1,
                one_rec(KIND_END, 16'h0006, 16'h1234, 16'd0, 8'h00));
        add_row(pack_bytes(8'h01, 8'hFF, 8'h07, 8'h00, 4'hF), 1'b1, 1'b0, '0);
        add_row(36'hF_FFFF_FFFF, 1'b1, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < n_open; i++) begin
            row = stim_rows[i];
            send_word(row.word, row.typed, row.has_rec, row.rec);
        end

        // Pause until the block is empty, then plan from the settled model.
        drain_results();
        plan_st = tape_st;

        // Random words; past the budget, only finish the open block so the
        // closing rows start on a hunting parser.
        n_rand = 0;
        while (n_rand < RANDOM_WORDS || plan_st.phase != SEEK_TYPE) begin
            closing = (n_rand >= RANDOM_WORDS);
            if (n_rand == 50) begin
                big_due = 1'b1;
            end
            b0 = plan_byte();
            b1 = plan_byte();
            b2 = plan_byte();
            b3 = plan_byte();
            send_word(pack_bytes(b0, b1, b2, b3, 4'($urandom_range(0, 15))),
                      1'b0, 1'b0, '0);
            n_rand++;
        end

        for (i = n_open; i < stim_rows.size(); i++) begin
            row = stim_rows[i];
            send_word(row.word, row.typed, row.has_rec, row.rec);
        end

        // Wait out the owed results, then watch for strays.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- absolute_loader_block_parser.f -----
hdl/alb_pkg.sv
hdl/alb_front.sv
hdl/alb_byte_queue.sv
hdl/alb_back.sv
hdl/alb_result_queue.sv
hdl/absolute_loader_block_parser.sv
test/tb_absolute_loader_block_parser.sv
